### sv/msa_pkg.sv
`default_nettype none

package msa_pkg;

  localparam int DEPTH  = 128;
  localparam int STACKS = 4;
  localparam int DATA_W = 32;
  localparam int MEM_AW = $clog2(DEPTH);
  localparam int SLOT_W = 11;

  localparam logic [1:0] FUNC_PUSH = 2'd0;
  localparam logic [1:0] FUNC_POP  = 2'd1;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_EMPTY     = 2'd2;
  localparam logic [1:0] ST_BAD_INDEX = 2'd3;

  localparam logic [1:0] REG_STACK_COUNT     = 2'd0;
  localparam logic [1:0] REG_PARTITION_SLOTS = 2'd1;
  localparam logic [1:0] REG_TOTAL_SLOTS     = 2'd2;

  localparam logic signed [DATA_W-1:0] POP_REFUSED = -32'sd1;

  typedef struct packed {
    logic [1:0]               func;
    logic [1:0]               stack_index;
    logic signed [DATA_W-1:0] push_value;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] pop_value;
    logic [1:0]               status;
    logic                     is_full;
    logic                     is_empty;
  } out_item_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_RDWAIT
  } state_t;

endpackage

`default_nettype wire

### sv/msa_ram.sv
`default_nettype none

module msa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     en,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

`default_nettype wire

### sv/multi_stack_shared_array.sv
// Several LIFO stacks sharing one 128-word data memory, cut into partitions.
// Command channel: an operation beat (func, stack_index, push_value) is taken
// at a rising edge with start high and busy low. busy stays high until the
// operation is finished.
// Result channel: out_valid is high for exactly one cycle with out_data
// (pop_value, status, is_full, is_empty). The receiver cannot stall it.
// Result path: push, status and refused operations register their result
// from the execute state; a pop that reads memory passes a read-wait state
// first, for the registered read of the single-port data memory.
// A new operation is taken only once the last one is finished; the
// read-modify-write of one fill counter and one memory word per
// operation sets this limit.
// Configuration: APB-style port, registers at byte addresses 0 (stack_count),
// 4 (partition_slots) and 8 (total_slots); write only while busy is low.
// Reset: synchronous, active low; clears all fill counters, loads the
// register defaults 3, 42 and 126, and leaves the data memory as it is.
`default_nettype none

module multi_stack_shared_array (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire msa_pkg::in_item_t  in_data,
  output logic                    out_valid,
  output msa_pkg::out_item_t      out_data,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [3:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic      [31:0]        prdata,
  output logic                    pready
);

  import msa_pkg::*;

  state_t    state_r, state_nxt;
  in_item_t  in_r;
  out_item_t out_r, out_nxt;
  logic      out_valid_r;
  logic [7:0] fill_r [STACKS];
  logic [7:0] fill_nxt;
  logic       fill_we;
  logic [2:0] stack_count_r;
  logic [7:0] partition_slots_r;
  logic [7:0] total_slots_r;

  logic [2:0]        used_n;
  logic              bad_idx;
  logic              last_stack;
  logic [SLOT_W-1:0] base;
  logic [SLOT_W-1:0] cap_raw;
  logic [SLOT_W-1:0] cap;
  logic [SLOT_W-1:0] room;
  logic [SLOT_W-1:0] fill_ext;
  logic [SLOT_W-1:0] push_addr;
  logic [SLOT_W-1:0] pop_addr;
  logic [7:0]        fill_cur;
  logic              is_push;
  logic              is_pop;
  logic              pop_ok;
  logic              pop_in_range;
  logic              go_read;

  logic              ram_en;
  logic              ram_we;
  logic [MEM_AW-1:0] ram_addr;
  logic [DATA_W-1:0] ram_rdata;

  msa_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .en    (ram_en),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (in_r.push_value),
    .rdata (ram_rdata)
  );

  always_comb begin
    used_n     = (stack_count_r > 3'(STACKS)) ? 3'(STACKS) : stack_count_r;
    bad_idx    = {1'b0, in_r.stack_index} >= used_n;
    last_stack = (3'(in_r.stack_index) + 3'd1) == used_n;
    base       = SLOT_W'(in_r.stack_index) * SLOT_W'(partition_slots_r);
    if (last_stack) begin
      cap_raw = (SLOT_W'(total_slots_r) >= base) ? SLOT_W'(total_slots_r) - base : '0;
    end else begin
      cap_raw = SLOT_W'(partition_slots_r);
    end
    room = SLOT_W'(DEPTH) - base;
    if (base >= SLOT_W'(DEPTH)) begin
      cap = '0;
    end else if (cap_raw > room) begin
      cap = room;
    end else begin
      cap = cap_raw;
    end
    fill_cur     = fill_r[in_r.stack_index];
    fill_ext     = SLOT_W'(fill_cur);
    push_addr    = base + fill_ext;
    pop_addr     = base + fill_ext - SLOT_W'(1);
    is_push      = in_r.func == FUNC_PUSH;
    is_pop       = in_r.func == FUNC_POP;
    pop_ok       = is_pop && (fill_cur != 8'd0);
    pop_in_range = pop_addr < SLOT_W'(DEPTH);
    go_read      = !bad_idx && pop_ok && pop_in_range;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = go_read ? S_RDWAIT : S_IDLE;
      end
      S_RDWAIT: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    busy     = state_r != S_IDLE;
    ram_en   = 1'b0;
    ram_we   = 1'b0;
    ram_addr = MEM_AW'(push_addr);
    fill_we  = 1'b0;
    fill_nxt = fill_cur;
    out_nxt  = out_r;
    case (state_r)
      S_EXEC: begin
        out_nxt.pop_value = '0;
        out_nxt.status    = ST_OK;
        if (bad_idx) begin
          out_nxt.status = ST_BAD_INDEX;
        end else begin
          fill_we = 1'b1;
          if (is_push) begin
            if (fill_ext >= cap) begin
              out_nxt.status = ST_FULL;
            end else begin
              ram_en   = 1'b1;
              ram_we   = 1'b1;
              fill_nxt = fill_cur + 8'd1;
            end
          end else if (is_pop) begin
            if (!pop_ok) begin
              out_nxt.status    = ST_EMPTY;
              out_nxt.pop_value = POP_REFUSED;
            end else begin
              ram_en   = pop_in_range;
              ram_addr = MEM_AW'(pop_addr);
              fill_nxt = fill_cur - 8'd1;
            end
          end
        end
        out_nxt.is_full  = !bad_idx && (SLOT_W'(fill_nxt) >= cap);
        out_nxt.is_empty = !bad_idx && (fill_nxt == 8'd0);
      end
      S_RDWAIT: begin
        out_nxt.pop_value = ram_rdata;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r           <= S_IDLE;
      out_valid_r       <= 1'b0;
      stack_count_r     <= 3'd3;
      partition_slots_r <= 8'd42;
      total_slots_r     <= 8'd126;
      for (int i = 0; i < STACKS; i++) begin
        fill_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= (state_r == S_RDWAIT) || (state_r == S_EXEC && !go_read);
      if (fill_we) begin
        fill_r[in_r.stack_index] <= fill_nxt;
      end
      if (psel && penable && pwrite) begin
        case (paddr[3:2])
          REG_STACK_COUNT:     stack_count_r     <= pwdata[2:0];
          REG_PARTITION_SLOTS: partition_slots_r <= pwdata[7:0];
          REG_TOTAL_SLOTS:     total_slots_r     <= pwdata[7:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      in_r <= in_data;
    end
    out_r <= out_nxt;
  end

  always_comb begin
    case (paddr[3:2])
      REG_STACK_COUNT:     prdata = {29'd0, stack_count_r};
      REG_PARTITION_SLOTS: prdata = {24'd0, partition_slots_r};
      REG_TOTAL_SLOTS:     prdata = {24'd0, total_slots_r};
      default:             prdata = '0;
    endcase
  end

  assign pready    = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> state_r == S_EXEC)
    else $error("accepted beat did not enter execute");

  a_ram_in_exec: assert property (@(posedge clk) disable iff (!rst_n)
    ram_en |-> state_r == S_EXEC)
    else $error("memory access outside execute");

  a_read_ok: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_RDWAIT |-> out_r.status == ST_OK && $past(state_r) == S_EXEC)
    else $error("read wait without a successful pop");

  a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ($past(state_r) == S_EXEC || $past(state_r) == S_RDWAIT)
      && state_r == S_IDLE)
    else $error("result beat outside of an operation");

endmodule

`default_nettype wire

### test/tb_multi_stack_shared_array.sv
`default_nettype none

module tb_multi_stack_shared_array;
  timeunit 1ns;
  timeprecision 1ps;

  import msa_pkg::*;

  localparam logic [1:0] FUNC_CHECK = 2'd2;
  localparam logic [1:0] FUNC_SPARE = 2'd3;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  in_item_t    in_data = '0;
  logic        out_valid;
  out_item_t   out_data;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  logic [31:0] stack_words [DEPTH];
  logic [7:0]  stack_level [STACKS];
  logic [2:0]  cfg_count = 3'd3;
  logic [7:0]  cfg_part = 8'd42;
  logic [7:0]  cfg_total = 8'd126;

  in_item_t  pending_ops [$];
  out_item_t expected_results [$];
  out_item_t want;
  int        ops_raised = 0;
  int        ops_accepted = 0;
  int        gap_left = 0;
  bit        gapless = 1'b0;
  int        fault_count = 0;

  multi_stack_shared_array DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always #5 clk = ~clk;

  function automatic out_item_t apply_stack_op(in_item_t op);
    out_item_t r;
    int        used;
    int        base;
    int        room;
    int        lvl;
    int        addr;
    r = '0;
    used = (int'(cfg_count) > STACKS) ? STACKS : int'(cfg_count);
    if (int'(op.stack_index) >= used) begin
      r.status = ST_BAD_INDEX;
      return r;
    end
    base = int'(op.stack_index) * int'(cfg_part);
    room = int'(cfg_part);
    if (int'(op.stack_index) == used - 1)
      room = (int'(cfg_total) >= base) ? int'(cfg_total) - base : 0;
    if (base >= DEPTH)
      room = 0;
    else if (room > DEPTH - base)
      room = DEPTH - base;
    lvl = int'(stack_level[op.stack_index]);
    r.status = ST_OK;
    case (op.func)
      FUNC_PUSH: begin
        if (lvl >= room) begin
          r.status = ST_FULL;
        end else begin
          stack_words[base + lvl] = op.push_value;
          lvl++;
        end
      end
      FUNC_POP: begin
        if (lvl == 0) begin
          r.status = ST_EMPTY;
          r.pop_value = POP_REFUSED;
        end else begin
          addr = base + lvl - 1;
          r.pop_value = (addr < DEPTH) ? stack_words[addr] : '0;
          lvl--;
        end
      end
      default: ;
    endcase
    stack_level[op.stack_index] = lvl[7:0];
    r.is_full = (lvl >= room);
    r.is_empty = (lvl == 0);
    return r;
  endfunction

  function automatic logic [31:0] draw_value();
    case ($urandom_range(0, 15))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0000_0000;
      3: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  task automatic queue_op(input logic [1:0] func, input logic [1:0] idx,
                          input logic [31:0] value);
    in_item_t op;
    op.func = func;
    op.stack_index = idx;
    op.push_value = value;
    pending_ops.push_back(op);
  endtask

  task automatic queue_stack_traffic(input int n);
    int         used;
    int         push_pct;
    int         r;
    logic [1:0] func;
    logic [1:0] idx;
    used = (int'(cfg_count) > STACKS) ? STACKS : int'(cfg_count);
    push_pct = 50;
    for (int k = 0; k < n; k++) begin
      if (k % 20 == 0)
        push_pct = $urandom_range(15, 85);
      r = $urandom_range(0, 99);
      if (r < push_pct * 94 / 100)
        func = FUNC_PUSH;
      else if (r < 94)
        func = FUNC_POP;
      else
        func = $urandom_range(0, 1) ? FUNC_CHECK : FUNC_SPARE;
      if (used > 0 && $urandom_range(0, 9) != 0)
        idx = 2'($urandom_range(0, used - 1));
      else
        idx = 2'($urandom_range(0, 3));
      queue_op(func, idx, draw_value());
    end
  endtask

  task automatic wait_drained();
    while (pending_ops.size() > 0 || ops_accepted != ops_raised
           || expected_results.size() > 0)
      @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_STACK_COUNT:     cfg_count = value[2:0];
      REG_PARTITION_SLOTS: cfg_part = value[7:0];
      REG_TOTAL_SLOTS:     cfg_total = value[7:0];
      default: ;
    endcase
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic load_stack_config(input logic [2:0] n, input logic [7:0] part,
                                   input logic [7:0] total);
    wait_drained();
    repeat (4) @(posedge clk);
    write_reg(REG_STACK_COUNT, 32'(n));
    write_reg(REG_PARTITION_SLOTS, 32'(part));
    write_reg(REG_TOTAL_SLOTS, 32'(total));
    gapless = ($urandom_range(0, 3) == 0);
  endtask

  always @(negedge clk) begin
    if (rst_n && (!start || ops_accepted == ops_raised)) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        start    <= 1'b0;
      end else if (pending_ops.size() > 0) begin
        in_data    <= pending_ops.pop_front();
        start      <= 1'b1;
        ops_raised <= ops_raised + 1;
        gap_left   <= gapless ? 0 : int'($urandom_range(0, 9));
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (expected_results.size() == 0) begin
        fault_count++;
        if (fault_count <= 10)
          $display("result beat with nothing pending: pop_value %0d status %0d full %0b empty %0b",
                   out_data.pop_value, out_data.status, out_data.is_full, out_data.is_empty);
      end else begin
        want = expected_results.pop_front();
        if (out_data.pop_value !== want.pop_value || out_data.status !== want.status
            || out_data.is_full !== want.is_full || out_data.is_empty !== want.is_empty) begin
          fault_count++;
          if (fault_count <= 10)
            $display("bad result beat: expected %0d/%0d/%0b/%0b, got %0d/%0d/%0b/%0b",
                     want.pop_value, want.status, want.is_full, want.is_empty,
                     out_data.pop_value, out_data.status, out_data.is_full,
                     out_data.is_empty);
        end
      end
    end
    if (rst_n && start && !busy) begin
      expected_results.push_back(apply_stack_op(in_data));
      ops_accepted <= ops_accepted + 1;
    end
  end

  initial begin
    foreach (stack_level[s]) stack_level[s] = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    load_stack_config(3'd4, 8'd64, 8'd128);
    queue_op(FUNC_CHECK, 2'd2, draw_value());
    queue_op(FUNC_PUSH, 2'd2, draw_value());
    queue_op(FUNC_CHECK, 2'd3, draw_value());

    load_stack_config(3'd4, 8'd32, 8'd128);
    queue_op(FUNC_CHECK, 2'd0, draw_value());
    queue_op(FUNC_SPARE, 2'd3, draw_value());
    queue_op(FUNC_POP, 2'd0, draw_value());
    queue_op(FUNC_PUSH, 2'd1, 32'h8000_0000);
    queue_op(FUNC_PUSH, 2'd1, 32'h7FFF_FFFF);
    queue_op(FUNC_PUSH, 2'd1, 32'h0000_0000);
    queue_op(FUNC_PUSH, 2'd1, 32'hFFFF_FFFF);
    queue_op(FUNC_CHECK, 2'd1, draw_value());
    repeat (5) queue_op(FUNC_POP, 2'd1, draw_value());
    for (int s = 0; s < STACKS; s++) begin
      repeat (33) queue_op(FUNC_PUSH, 2'(s), draw_value());
      queue_op(FUNC_CHECK, 2'(s), draw_value());
    end

    load_stack_config(3'd4, 8'd100, 8'd128);
    queue_op(FUNC_POP, 2'd2, draw_value());
    queue_op(FUNC_POP, 2'd3, draw_value());
    queue_op(FUNC_PUSH, 2'd2, draw_value());
    queue_op(FUNC_CHECK, 2'd1, draw_value());
    queue_op(FUNC_POP, 2'd1, draw_value());

    load_stack_config(3'd2, 8'd100, 8'd50);
    queue_op(FUNC_CHECK, 2'd1, draw_value());
    queue_op(FUNC_PUSH, 2'd3, draw_value());
    queue_op(FUNC_POP, 2'd2, draw_value());

    load_stack_config(3'd0, 8'd32, 8'd128);
    queue_op(FUNC_POP, 2'd0, draw_value());

    load_stack_config(3'd7, 8'd32, 8'd128);
    queue_op(FUNC_POP, 2'd3, draw_value());

    load_stack_config(3'd7, 8'd255, 8'd255);
    queue_stack_traffic(145);
    load_stack_config(3'd1, 8'd1, 8'd1);
    queue_stack_traffic(145);
    load_stack_config(3'd0, 8'd0, 8'd0);
    queue_stack_traffic(145);
    load_stack_config(3'd4, 8'd128, 8'd128);
    queue_stack_traffic(145);
    load_stack_config(3'd2, 8'd8, 8'd16);
    queue_stack_traffic(145);
    load_stack_config(3'd3, 8'd42, 8'd126);
    queue_stack_traffic(145);
    repeat (8) begin
      logic [2:0] n;
      logic [7:0] part;
      logic [7:0] total;
      n = ($urandom_range(0, 9) < 8) ? 3'($urandom_range(1, 4)) : 3'($urandom_range(0, 7));
      part = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                         : 8'($urandom_range(1, 24));
      if ($urandom_range(0, 3) == 0)
        total = 8'($urandom_range(0, 255));
      else if (int'(part) * int'(n) + 3 > 255)
        total = 8'd255;
      else
        total = 8'(int'(part) * int'(n) + int'($urandom_range(0, 3)));
      load_stack_config(n, part, total);
      queue_stack_traffic(145);
    end

    wait_drained();
    repeat (8) @(posedge clk);
    fault_count += expected_results.size();
    if (fault_count == 0)
      $display("multi_stack_shared_array: match");
    else
      $display("multi_stack_shared_array: mismatch");
    $finish;
  end

  initial begin
    #5ms;
    $display("multi_stack_shared_array: mismatch");
    $finish;
  end

endmodule

`default_nettype wire

### multi_stack_shared_array.f
sv/msa_pkg.sv
sv/msa_ram.sv
sv/multi_stack_shared_array.sv
test/tb_multi_stack_shared_array.sv
